// ===== rtl/srec_pkg.sv =====
// Shared types and constants for the S-record page assembler.
// No dependencies; srec_ctrl, srec_dp and the top level import this package.
`default_nettype none
package srec_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_SIZE     = 3'd2,
    ST_TYPE     = 3'd3,
    ST_TERM     = 3'd4,
    ST_HEADER   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_FREAD,
    CS_FWAIT
  } ctrl_state_t;

  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] SUM_OK  = 8'hFF;
  localparam logic [7:0] HDR_LEN = 8'd3;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_LIMIT = 10'd1023;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_FIRST_PAGE = 1'b0;

  typedef struct packed {
    logic accept;
    logic word_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic flush_req;
    logic last_word;
  } dp_stat_t;

  function automatic logic [7:0] nibble_value(input logic [7:0] c);
    if (c <= CH_9) begin
      return c - CH_0;
    end
    return c - CH_A + 8'd10;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] hn;
    logic [7:0] h;
    hn = nibble_value(hi);
    h  = {hn[3:0], 4'b0000};
    return h + nibble_value(lo);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/srec_if.sv =====
// Stream interfaces for the character input and the result output.
// Depends on nothing; payload widths are fixed by the field definitions.
`default_nettype none
interface srec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_record;
  modport source (output valid, char_code, end_of_record, input ready);
  modport sink (input valid, char_code, end_of_record, output ready);
endinterface

interface srec_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [2:0]  status;
  logic [7:0]  page_number;
  logic [7:0]  page_bytes;
  logic [3:0]  word_index;
  logic [63:0] data_word;
  logic        last;
  modport source (output valid, item_kind, status, page_number, page_bytes, word_index,
                  data_word, last, input ready);
  modport sink (input valid, item_kind, status, page_number, page_bytes, word_index,
                data_word, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/srec_ctrl.sv =====
// Controller: accepts characters and sequences the page flush.
// Depends on srec_pkg; drives the datapath through dp_cmd_t.
`default_nettype none
module srec_ctrl
  import srec_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_eor,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (in_valid && stat.out_free && in_eor && stat.flush_req) begin
          state_next = CS_FREAD;
        end
      end
      CS_FREAD: state_next = CS_FWAIT;
      CS_FWAIT: begin
        if (stat.out_free) begin
          state_next = stat.last_word ? CS_IDLE : CS_FREAD;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.word_load = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
      end
      CS_FWAIT: cmd.word_load = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/srec_dp.sv =====
// Datapath: record parser, checksum, page buffer memory and result register.
// Depends on srec_pkg; commanded by srec_ctrl.
`default_nettype none
module srec_dp
  import srec_pkg::*;
#(
  parameter int unsigned PAGE_BYTES       = 128,
  parameter int unsigned RECORDS_PER_PAGE = 8,
  parameter int unsigned MAX_BYTE_COUNT   = 19
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic [7:0] char_code,
  input  wire logic    end_of_record,
  input  wire logic    cfg_we,
  input  wire logic [7:0] cfg_data,
  output logic [7:0]   first_page,
  input  wire dp_cmd_t cmd,
  output dp_stat_t     stat,
  input  wire logic    out_ready,
  output logic         out_valid,
  output logic         out_kind,
  output logic [2:0]   out_status,
  output logic [7:0]   out_page,
  output logic [7:0]   out_bytes,
  output logic [3:0]   out_widx,
  output logic [63:0]  out_data,
  output logic         out_last
);

  localparam int unsigned AW         = $clog2(PAGE_BYTES);
  localparam int unsigned WW         = AW - 3;
  localparam int unsigned FW         = $clog2(PAGE_BYTES + 1);
  localparam int unsigned PAGE_WORDS = (PAGE_BYTES + 7) / 8;
  localparam int unsigned RCW        = $clog2(RECORDS_PER_PAGE + 1);

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       bc, bc_next, sum, sum_next, hold, hold_next, rtype, rtype_next;
  status_t          rstat, rstat_next, st, flush_st;
  logic [FW-1:0]    fill, fill_next;
  logic [RCW-1:0]   rc, rc_next;
  logic [7:0]       page;
  logic [WW-1:0]    widx;
  logic             wr_en, flush;
  logic [7:0]       pair_b, dl, dl_next;
  logic [POS_W-1:0] k, count_now;
  logic [8:0]       p;
  logic [63:0]      mem [PAGE_WORDS];
  logic [63:0]      rd_data, masked;
  logic [FW+7:0]    fill_wide;
  logic [WW+3:0]    widx_wide;

  assign pair_b  = pair_value(hold, char_code);
  assign dl      = (bc >= HDR_LEN) ? bc - HDR_LEN : 8'd0;
  assign k       = pos - POS_W'(2);
  assign p       = k[POS_W-1:1];
  assign count_now = (pos < POS_LIMIT) ? pos + POS_W'(1) : POS_LIMIT;

  always_comb begin
    bc_next    = bc;
    sum_next   = sum;
    hold_next  = hold;
    rtype_next = rtype;
    rstat_next = rstat;
    fill_next  = fill;
    wr_en      = 1'b0;
    if (pos == '0) begin
      bc_next    = '0;
      sum_next   = '0;
      hold_next  = '0;
      rtype_next = '0;
      rstat_next = (char_code == CH_S) ? ST_OK : ST_HEADER;
    end else if (pos == POS_W'(1)) begin
      rtype_next = char_code;
    end else if (rstat == ST_OK && rtype == CH_1) begin
      if (!k[0]) begin
        hold_next = char_code;
      end else if (p == '0) begin
        bc_next  = pair_b;
        sum_next = pair_b;
        if (pair_b > 8'(MAX_BYTE_COUNT)) begin
          rstat_next = ST_SIZE;
        end
      end else if (p <= 9'd3 + {1'b0, dl}) begin
        sum_next = sum + pair_b;
        if (p >= 9'd3 && p < 9'd3 + {1'b0, dl} && fill < FW'(PAGE_BYTES)) begin
          wr_en     = 1'b1;
          fill_next = fill + FW'(1);
        end
      end
    end
  end

  assign dl_next = (bc_next >= HDR_LEN) ? bc_next - HDR_LEN : 8'd0;

  // Final status of the record, evaluated on its last character.
  always_comb begin
    rc_next = rc;
    if (rstat_next == ST_HEADER) begin
      st = ST_HEADER;
    end else if (count_now < POS_W'(2)) begin
      st = ST_TYPE;
    end else if (rtype_next == CH_9) begin
      st = ST_TERM;
    end else if (rtype_next == CH_0) begin
      st = ST_OK;
    end else if (rtype_next != CH_1) begin
      st = ST_TYPE;
    end else if (rstat_next == ST_SIZE) begin
      st = ST_SIZE;
    end else if (count_now < POS_W'(4)) begin
      st = ST_CHECKSUM;
    end else begin
      rc_next = rc + RCW'(1);
      if (count_now >= POS_W'(10) + {1'b0, dl_next, 1'b0} && sum_next == SUM_OK) begin
        st = ST_OK;
      end else begin
        st = ST_CHECKSUM;
      end
    end
  end

  assign flush = (rc_next >= RCW'(RECORDS_PER_PAGE)) || (st == ST_TERM);

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.flush_req = flush;
  assign stat.last_word = (widx == WW'(PAGE_WORDS - 1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill[AW-1:3]][fill[2:0]*8 +: 8] <= pair_b;
    end
    rd_data <= mem[widx];
  end

  // Bytes at or past the fill level read as zero.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      masked[j*8 +: 8] = ({1'b0, widx, 3'(j)} < (WW+4)'(fill)) ? rd_data[j*8 +: 8] : 8'd0;
    end
  end

  assign fill_wide = {8'd0, fill_next};
  assign widx_wide = {4'd0, widx};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      bc         <= '0;
      sum        <= '0;
      hold       <= '0;
      rtype      <= '0;
      rstat      <= ST_OK;
      fill       <= '0;
      rc         <= '0;
      page       <= '0;
      first_page <= '0;
      widx       <= '0;
      out_valid  <= 1'b0;
      flush_st   <= ST_OK;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        first_page <= cfg_data;
        page       <= cfg_data;
      end
      if (cmd.accept) begin
        bc    <= bc_next;
        sum   <= sum_next;
        hold  <= hold_next;
        rtype <= rtype_next;
        fill  <= fill_next;
        if (end_of_record) begin
          pos        <= '0;
          rstat      <= ST_OK;
          rc         <= rc_next;
          flush_st   <= st;
          out_valid  <= 1'b1;
          out_kind   <= 1'b0;
          out_status <= st;
          out_page   <= page;
          out_bytes  <= fill_wide[7:0];
          out_widx   <= 4'd0;
          out_data   <= 64'd0;
          out_last   <= !flush;
        end else begin
          pos   <= count_now;
          rstat <= rstat_next;
        end
      end
      if (cmd.word_load) begin
        out_valid  <= 1'b1;
        out_kind   <= 1'b1;
        out_status <= flush_st;
        out_page   <= page;
        out_bytes  <= 8'(fill);
        out_widx   <= widx_wide[3:0];
        out_data   <= masked;
        out_last   <= stat.last_word;
        if (stat.last_word) begin
          widx <= '0;
          fill <= '0;
          rc   <= '0;
          page <= page + 8'd1;
        end else begin
          widx <= widx + WW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/srec_s1_record_page_assembler.sv =====
// S1 record page assembler top level: APB register port, controller, datapath.
// Depends on srec_pkg, srec_if, srec_ctrl and srec_dp.
`default_nettype none
// Takes S-record text one character per transaction and gives one status
// transaction per record, on the character flagged as the record's end. After
// RECORDS_PER_PAGE counted S1 records, or on an S9 record, the page buffer
// follows as ceil(PAGE_BYTES/8) 64-bit word transactions. A character is taken
// while the output register is free; a flush reads each word through the registered
// read port of the page memory, and holds off input until its last word is loaded.
// Register first_page sits at byte address 0 and loads the page counter.
module srec_s1_record_page_assembler
  import srec_pkg::*;
#(
  parameter int unsigned PAGE_BYTES       = 128,
  parameter int unsigned RECORDS_PER_PAGE = 8,
  parameter int unsigned MAX_BYTE_COUNT   = 19
) (
  input  wire logic               clk,
  input  wire logic               rst,
  srec_in_if.sink                 in_s,
  srec_out_if.source              out_s,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       cfg_we;
  logic [7:0] first_page;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FIRST_PAGE);
  assign prdata = (paddr[2] == REG_FIRST_PAGE) ? {24'd0, first_page} : 32'd0;

  srec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_s.valid),
    .in_eor   (in_s.end_of_record),
    .in_ready (in_s.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srec_dp #(
    .PAGE_BYTES       (PAGE_BYTES),
    .RECORDS_PER_PAGE (RECORDS_PER_PAGE),
    .MAX_BYTE_COUNT   (MAX_BYTE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .char_code     (in_s.char_code),
    .end_of_record (in_s.end_of_record),
    .cfg_we        (cfg_we),
    .cfg_data      (pwdata[7:0]),
    .first_page    (first_page),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_s.ready),
    .out_valid     (out_s.valid),
    .out_kind      (out_s.item_kind),
    .out_status    (out_s.status),
    .out_page      (out_s.page_number),
    .out_bytes     (out_s.page_bytes),
    .out_widx      (out_s.word_index),
    .out_data      (out_s.data_word),
    .out_last      (out_s.last)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for the S1 record page assembler: random S-record text in,
// status and page word transactions out, checked against an in-bench parser model.
// Depends on srec_pkg, srec_if and the assembler RTL.
`timescale 1ns / 100ps
module tb_top;
  import srec_pkg::*;

  localparam int unsigned PAGE_SIZE   = 128;
  localparam int unsigned PAGE_RECS   = 8;
  localparam int unsigned MAX_COUNT   = 19;
  localparam int unsigned PAGE_WORDS  = (PAGE_SIZE + 7) / 8;
  localparam int unsigned WATCHDOG    = 4000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] code;
    logic       eor;
  } srec_char_t;

  typedef struct {
    logic        kind;
    logic [2:0]  st;
    logic [7:0]  page;
    logic [7:0]  nbytes;
    logic [3:0]  widx;
    logic [63:0] word;
    logic        last;
  } page_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  srec_in_if  in_if();
  srec_out_if out_if();

  srec_s1_record_page_assembler i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_s    (in_if),
    .out_s   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  srec_char_t   char_backlog[$];
  page_result_t due_results[$];
  page_result_t seen_results[$];
  int unsigned  fail_count = 0;
  int unsigned  chars_sent = 0;
  int unsigned  records_seen = 0;
  int unsigned  pages_flushed = 0;
  int unsigned  idle_cycles = 0;
  bit           hold_go = 1'b0;

  // Parser state mirrored from the block.
  logic [7:0]  pg_store[PAGE_SIZE];
  int unsigned fill = 0;
  int unsigned rec_cnt = 0;
  logic [7:0]  page_ctr = 8'd0;
  int unsigned char_pos = 0;
  logic [7:0]  byte_cnt = 8'd0;
  logic [7:0]  sum = 8'd0;
  logic [7:0]  hi_char = 8'd0;
  status_t     rec_st = ST_OK;
  logic [7:0]  rec_type = 8'd0;

  function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
    if (c <= CH_9) return c - CH_0;
    return c - CH_A + 8'd10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_0 + 8'(n);
    return CH_A + 8'(n) - 8'd10;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic eor);
    int unsigned dlen, k, p, w, j;
    logic [7:0]  h, b;
    logic [63:0] word;
    status_t     st;
    bit          flush;
    page_result_t r;
    if (char_pos == 0) begin
      byte_cnt = 0; sum = 0; hi_char = 0; rec_type = 0;
      rec_st = (c == CH_S) ? ST_OK : ST_HEADER;
    end else if (char_pos == 1) begin
      rec_type = c;
    end else if (rec_st == ST_OK && rec_type == CH_1) begin
      k = char_pos - 2;
      if (k[0] == 1'b0) begin
        hi_char = c;
      end else begin
        h = hex_digit_value(hi_char);
        b = {h[3:0], 4'h0} + hex_digit_value(c);
        p = k >> 1;
        dlen = (byte_cnt >= 3) ? byte_cnt - 3 : 0;
        if (p == 0) begin
          byte_cnt = b;
          sum = b;
          if (b > MAX_COUNT) rec_st = ST_SIZE;
        end else if (p <= 3 + dlen) begin
          sum = sum + b;
          if (p >= 3 && p < 3 + dlen && fill < PAGE_SIZE) begin
            pg_store[fill] = b;
            fill++;
          end
        end
      end
    end
    char_pos = (char_pos < 1023) ? char_pos + 1 : 1023;
    if (!eor) return;

    dlen = (byte_cnt >= 3) ? byte_cnt - 3 : 0;
    if (rec_st == ST_HEADER) st = ST_HEADER;
    else if (char_pos < 2) st = ST_TYPE;
    else if (rec_type == CH_9) st = ST_TERM;
    else if (rec_type == CH_0) st = ST_OK;
    else if (rec_type != CH_1) st = ST_TYPE;
    else if (rec_st == ST_SIZE) st = ST_SIZE;
    else if (char_pos < 4) st = ST_CHECKSUM;
    else begin
      rec_cnt++;
      if (char_pos >= 2 + 2 * (4 + dlen) && sum == SUM_OK) st = ST_OK;
      else st = ST_CHECKSUM;
    end
    char_pos = 0;
    rec_st = ST_OK;
    records_seen++;

    flush = (rec_cnt >= PAGE_RECS) || (st == ST_TERM);
    r = '{kind: 1'b0, st: st, page: page_ctr, nbytes: 8'(fill), widx: 4'd0,
          word: 64'd0, last: !flush};
    due_results.push_back(r);
    if (flush) begin
      for (w = 0; w < PAGE_WORDS; w++) begin
        word = 64'd0;
        for (j = 0; j < 8; j++)
          if (w * 8 + j < fill) word[8*j +: 8] = pg_store[w * 8 + j];
        r = '{kind: 1'b1, st: st, page: page_ctr, nbytes: 8'(fill), widx: 4'(w),
              word: word, last: (w + 1 == PAGE_WORDS)};
        due_results.push_back(r);
      end
      rec_cnt = 0;
      fill = 0;
      page_ctr = page_ctr + 8'd1;
      pages_flushed++;
    end
  endtask

  // Stimulus builders.
  task automatic queue_text(ref logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++)
      char_backlog.push_back('{code: text[i], eor: (i == text.size() - 1)});
    chars_sent += text.size();
  endtask

  task automatic queue_s1(input int unsigned cnt, input bit corrupt, input int unsigned cut,
                          input int unsigned extra);
    logic [7:0] bytes[$];
    logic [7:0] text[$];
    logic [7:0] total;
    int unsigned dlen;
    dlen = (cnt >= 3) ? cnt - 3 : 0;
    if (dlen > 20) dlen = 20;
    bytes.push_back(8'(cnt));
    bytes.push_back(8'($urandom));
    bytes.push_back(8'($urandom));
    for (int i = 0; i < dlen; i++) bytes.push_back(8'($urandom));
    total = 0;
    foreach (bytes[i]) total += bytes[i];
    bytes.push_back(corrupt ? ~total ^ 8'($urandom_range(1, 255)) : ~total);
    text.push_back(CH_S);
    text.push_back(CH_1);
    foreach (bytes[i]) begin
      text.push_back(hex_char(bytes[i][7:4]));
      text.push_back(hex_char(bytes[i][3:0]));
    end
    for (int i = 0; i < extra; i++) text.push_back(8'($urandom));
    if (cut > 0 && cut < text.size()) text = text[0:cut-1];
    queue_text(text);
  endtask

  task automatic queue_typed(input logic [7:0] t, input int unsigned body);
    logic [7:0] text[$];
    text.push_back(CH_S);
    text.push_back(t);
    for (int i = 0; i < body; i++) text.push_back(hex_char(4'($urandom)));
    queue_text(text);
  endtask

  task automatic queue_noise(input int unsigned len);
    logic [7:0] text[$];
    for (int i = 0; i < len; i++) text.push_back(8'($urandom));
    queue_text(text);
  endtask

  task automatic queue_random_record();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) queue_s1($urandom_range(0, 8), 1'b0, 0, 0);
    else if (pick < 65) queue_s1(MAX_COUNT, 1'b0, 0, 0);
    else if (pick < 72) queue_s1($urandom_range(3, 12), 1'b1, 0, 0);
    else if (pick < 76) queue_s1($urandom_range(20, 255), 1'b0, 0, 0);
    else if (pick < 81) queue_s1($urandom_range(3, 12), 1'b0, $urandom_range(1, 12), 0);
    else if (pick < 84) queue_s1($urandom_range(3, 8), 1'b0, 0, $urandom_range(1, 4));
    else if (pick < 87) queue_typed(CH_0, $urandom_range(0, 10));
    else if (pick < 89) queue_typed(CH_9, $urandom_range(0, 10));
    else if (pick < 92) queue_typed(8'($urandom), $urandom_range(0, 6));
    else queue_noise($urandom_range(1, 8));
  endtask

  task automatic write_first_page(input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_FIRST_PAGE, 2'b00}; pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    page_ctr = value;
  endtask

  task automatic drain();
    while (char_backlog.size() > 0 || in_if.valid || due_results.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Character driver.
  int unsigned in_gap = 0;
  bit          in_quiet = 1'b0;
  always @(posedge clk) begin
    srec_char_t ch;
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.char_code <= 8'd0;
      in_if.end_of_record <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) parse_char(in_if.char_code, in_if.end_of_record);
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (char_backlog.size() > 0) begin
          ch = char_backlog.pop_front();
          in_if.char_code <= ch.code;
          in_if.end_of_record <= ch.eor;
          in_if.valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
          in_gap = in_quiet ? 0 : $urandom_range(0, 8);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure and one long hold-off.
  int unsigned out_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  bit          out_quiet = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_results.push_back('{kind: out_if.item_kind, st: out_if.status,
                                 page: out_if.page_number, nbytes: out_if.page_bytes,
                                 widx: out_if.word_index, word: out_if.data_word,
                                 last: out_if.last});
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_stall = out_quiet ? 0 : $urandom_range(0, 8);
      end
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      else if (out_stall > 0) out_stall--;
      out_if.ready <= (hold_left == 0 && out_stall == 0);
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(negedge clk) begin
    page_result_t got, want;
    while (seen_results.size() > 0) begin
      got = seen_results.pop_front();
      if (due_results.size() == 0) begin
        report("unexpected transaction", {got.kind, got.st}, 64'd0);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind) report("item_kind", got.kind, want.kind);
        if (got.st !== want.st) report("status", got.st, want.st);
        if (got.page !== want.page) report("page_number", got.page, want.page);
        if (got.nbytes !== want.nbytes) report("page_bytes", got.nbytes, want.nbytes);
        if (got.widx !== want.widx) report("word_index", got.widx, want.widx);
        if (got.word !== want.word) report("data_word", got.word, want.word);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [7:0] text[$];
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every record type, error path and boundary.
    write_first_page(8'd0);
    text = '{8'h58};
    queue_text(text);                      // header error, one character
    text = '{CH_S};
    queue_text(text);                      // ends after its first character
    queue_typed(8'h35, 4);                 // unknown record type
    queue_typed(CH_0, 8);
    queue_s1(3, 1'b0, 0, 0);               // no data bytes
    queue_s1(0, 1'b0, 0, 0);               // count below three
    queue_s1(MAX_COUNT, 1'b0, 0, 0);
    queue_s1(MAX_COUNT + 1, 1'b0, 0, 0);   // size error
    queue_s1(255, 1'b0, 0, 0);
    queue_s1(6, 1'b1, 0, 0);               // bad checksum, still counted
    queue_s1(6, 1'b0, 3, 0);               // ends inside the count
    queue_s1(6, 1'b0, 9, 0);               // ends before the checksum
    queue_s1(5, 1'b0, 0, 3);               // trailing characters
    queue_noise(24);                       // random characters without a header
    text = '{8'hFF, 8'h00, 8'hAA, 8'h55};
    queue_text(text);
    queue_typed(CH_9, 2);                  // termination flushes the page
    drain();

    write_first_page(8'd255);
    hold_go = 1'b1;
    for (int i = 0; i < 8; i++) queue_s1(4, 1'b0, 0, 0);
    drain();

    write_first_page(8'($urandom));
    while (chars_sent < 360) begin
      queue_random_record();
      if (char_backlog.size() > 200) begin
        while (char_backlog.size() > 0) @(negedge clk);
      end
    end
    queue_typed(CH_9, 0);
    drain();

    $display("Covered %0d characters, %0d records and %0d page flushes.",
             chars_sent, records_seen, pages_flushed);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== srec_s1_record_page_assembler.f =====
rtl/srec_pkg.sv
rtl/srec_if.sv
rtl/srec_ctrl.sv
rtl/srec_dp.sv
rtl/srec_s1_record_page_assembler.sv
tb/tb_top.sv
